### hw/rtl/a2bp_pkg.sv
`default_nettype none

package a2bp_pkg;

    localparam int unsigned DEF_MAX_ROW_WIDTH = 4096;

    localparam int unsigned CHAN_W     = 8;
    localparam int unsigned WORD_W     = 16;
    localparam int unsigned BITPOS_W   = 4;
    localparam int unsigned ROW_CFG_W  = 13;

    localparam logic [ROW_CFG_W-1:0] ROW_WIDTH_RESET = 13'd16;
    localparam logic [CHAN_W-1:0]    ALPHA_LIMIT     = 8'h80;
    localparam logic [9:0]           LEVEL_BIAS      = 10'd127;
    localparam logic [WORD_W-1:0]    TOP_BIT         = 16'h8000;

    typedef enum logic [1:0] {
        LVL_BLACK = 2'd0,
        LVL_LOW   = 2'd1,
        LVL_HIGH  = 2'd2,
        LVL_WHITE = 2'd3
    } t_level;

    typedef struct packed {
        logic plane_one;
        logic plane_two;
    } t_plane_bits;

endpackage

`default_nettype wire

### hw/rtl/a2bp_classify.sv
`default_nettype none

module a2bp_classify
    import a2bp_pkg::*;
(
    input  wire logic [CHAN_W-1:0] i_alpha,
    input  wire logic [CHAN_W-1:0] i_red,
    input  wire logic [CHAN_W-1:0] i_green,
    input  wire logic [CHAN_W-1:0] i_blue,
    output t_plane_bits            o_bits
);

    logic [9:0] sum;
    t_level     level;

    assign sum   = 10'(i_red) + 10'(i_green) + 10'(i_blue) + LEVEL_BIAS;
    assign level = t_level'(sum[9:8]);

    always_comb begin
        o_bits = '0;
        if (i_alpha > ALPHA_LIMIT) begin
            unique case (level)
                LVL_WHITE: begin
                    o_bits.plane_one = 1'b0;
                    o_bits.plane_two = 1'b1;
                end
                LVL_LOW, LVL_HIGH: begin
                    o_bits.plane_one = 1'b1;
                    o_bits.plane_two = 1'b1;
                end
                LVL_BLACK: begin
                    o_bits.plane_one = 1'b1;
                    o_bits.plane_two = 1'b0;
                end
                default: begin
                    o_bits = '0;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

### hw/rtl/argb_to_two_bitplanes.sv
`default_nettype none

// channel   signals                                            direction
// pixel     i_in_valid, o_in_stall, i_alpha/red/green/blue     in
// words     o_out_valid, i_out_stall, o_plane_*_word, o_row_done out
// config    i_cfg_valid, o_cfg_ready, i_cfg_row_width          in
//
// one pixel per cycle unless stalled; a closed word is registered on its pixel's acceptance
// buffering is the output register plus one skid entry; full rate unless the output stalls
// o_in_stall rises only while the skid entry is occupied
// synchronous active-low reset; row width resets to 16, counters to zero
// o_cfg_ready is always high

module argb_to_two_bitplanes
    import a2bp_pkg::*;
#(
    parameter int unsigned MAX_ROW_WIDTH = DEF_MAX_ROW_WIDTH
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output      logic                 o_in_stall,
    input  wire logic [CHAN_W-1:0]    i_alpha,
    input  wire logic [CHAN_W-1:0]    i_red,
    input  wire logic [CHAN_W-1:0]    i_green,
    input  wire logic [CHAN_W-1:0]    i_blue,
    output      logic                 o_out_valid,
    input  wire logic                 i_out_stall,
    output      logic [WORD_W-1:0]    o_plane_one_word,
    output      logic [WORD_W-1:0]    o_plane_two_word,
    output      logic                 o_row_done,
    input  wire logic                 i_cfg_valid,
    output      logic                 o_cfg_ready,
    input  wire logic [ROW_CFG_W-1:0] i_cfg_row_width
);

    localparam int unsigned CNT_W = $clog2(MAX_ROW_WIDTH + 1);
    localparam int unsigned CMP_W = (CNT_W > ROW_CFG_W) ? CNT_W : ROW_CFG_W;
    localparam logic [CMP_W-1:0] MAX_W = CMP_W'(MAX_ROW_WIDTH);

    logic [ROW_CFG_W-1:0] r_row_width;
    logic [CNT_W-1:0]     r_col, n_col;
    logic [BITPOS_W-1:0]  r_bitpos, n_bitpos;
    logic [WORD_W-1:0]    r_acc_one, n_acc_one;
    logic [WORD_W-1:0]    r_acc_two, n_acc_two;

    logic                 r_out_valid;
    logic [WORD_W-1:0]    r_out_one, r_out_two;
    logic                 r_out_done;
    logic                 r_skid_valid;
    logic [WORD_W-1:0]    r_skid_one, r_skid_two;
    logic                 r_skid_done;

    t_plane_bits          bits;
    logic                 in_acc, out_take;
    logic [WORD_W-1:0]    mask, word_one, word_two;
    logic [CNT_W-1:0]     col_inc;
    logic [BITPOS_W-1:0]  bitpos_inc;
    logic [CMP_W-1:0]     width_ext, eff_width;
    logic                 word_full, row_end, emit;

    a2bp_classify u_classify (
        .i_alpha (i_alpha),
        .i_red   (i_red),
        .i_green (i_green),
        .i_blue  (i_blue),
        .o_bits  (bits)
    );

    assign in_acc      = i_in_valid && !o_in_stall;
    assign out_take    = r_out_valid && !i_out_stall;
    assign o_in_stall  = r_skid_valid;
    assign o_cfg_ready = 1'b1;

    // effective width: zero acts as one, saturate at the maximum
    always_comb begin
        width_ext = CMP_W'(r_row_width);
        if (width_ext == '0) begin
            eff_width = CMP_W'(1);
        end else if (width_ext > MAX_W) begin
            eff_width = MAX_W;
        end else begin
            eff_width = width_ext;
        end
    end

    assign mask       = TOP_BIT >> r_bitpos;
    assign word_one   = r_acc_one | (bits.plane_one ? mask : '0);
    assign word_two   = r_acc_two | (bits.plane_two ? mask : '0);
    assign col_inc    = r_col + CNT_W'(1);
    assign bitpos_inc = r_bitpos + BITPOS_W'(1);
    assign word_full  = (bitpos_inc == '0);
    assign row_end    = (CMP_W'(col_inc) >= eff_width);
    assign emit       = word_full || row_end;

    always_comb begin
        n_col     = r_col;
        n_bitpos  = r_bitpos;
        n_acc_one = r_acc_one;
        n_acc_two = r_acc_two;
        if (in_acc) begin
            n_col     = row_end ? '0 : col_inc;
            n_bitpos  = emit ? '0 : bitpos_inc;
            n_acc_one = emit ? '0 : word_one;
            n_acc_two = emit ? '0 : word_two;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_width <= ROW_WIDTH_RESET;
            r_col       <= '0;
            r_bitpos    <= '0;
            r_acc_one   <= '0;
            r_acc_two   <= '0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_row_width <= i_cfg_row_width;
            end
            r_col     <= n_col;
            r_bitpos  <= n_bitpos;
            r_acc_one <= n_acc_one;
            r_acc_two <= n_acc_two;
        end
    end

    // output register with one skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (out_take) begin
                if (r_skid_valid) begin
                    r_skid_valid <= 1'b0;
                    r_out_valid  <= 1'b1;
                end else begin
                    r_out_valid <= in_acc && emit;
                end
            end else if (in_acc && emit) begin
                if (r_out_valid) begin
                    r_skid_valid <= 1'b1;
                end else begin
                    r_out_valid <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_take && r_skid_valid) begin
            r_out_one  <= r_skid_one;
            r_out_two  <= r_skid_two;
            r_out_done <= r_skid_done;
        end else if (in_acc && emit && (out_take || !r_out_valid)) begin
            r_out_one  <= word_one;
            r_out_two  <= word_two;
            r_out_done <= row_end;
        end
        if (in_acc && emit && r_out_valid && !out_take) begin
            r_skid_one  <= word_one;
            r_skid_two  <= word_two;
            r_skid_done <= row_end;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_plane_one_word = r_out_one;
    assign o_plane_two_word = r_out_two;
    assign o_row_done       = r_out_done;

    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry held without an output word");

    a_skid_moves_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && !i_out_stall) |=> (r_out_valid && !r_skid_valid))
        else $error("skid entry not moved to output");

    a_row_start_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_col == '0) |-> (r_bitpos == '0 && r_acc_one == '0 && r_acc_two == '0))
        else $error("row start with partial word pending");

    a_emit_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && emit) |=> r_out_valid)
        else $error("emitted word lost");

endmodule

`default_nettype wire

### dv/tb_argb_to_two_bitplanes.sv
module tb_argb_to_two_bitplanes
    import a2bp_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned MAX_ROW = DEF_MAX_ROW_WIDTH;
    localparam int unsigned RANDOM_PIXELS = 1400;
    localparam int unsigned DIR_ROWS = 21;

    typedef struct packed {
        logic [CHAN_W-1:0] alpha;
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } t_argb;

    typedef struct packed {
        logic [WORD_W-1:0] one;
        logic [WORD_W-1:0] two;
        logic              done;
    } t_planes;

    typedef struct packed {
        logic                 is_cfg;
        logic [ROW_CFG_W-1:0] width;
        t_argb                px;
        logic                 known;
        t_planes              words;
    } t_dir_row;

    logic                 clk;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic [CHAN_W-1:0]    alpha = '0;
    logic [CHAN_W-1:0]    red = '0;
    logic [CHAN_W-1:0]    green = '0;
    logic [CHAN_W-1:0]    blue = '0;
    logic                 out_stall = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic [ROW_CFG_W-1:0] cfg_row_width = '0;
    logic                 in_stall;
    logic                 out_valid;
    logic [WORD_W-1:0]    plane_one_word;
    logic [WORD_W-1:0]    plane_two_word;
    logic                 row_done;
    logic                 cfg_ready;

    // shadow of the converter state
    logic [ROW_CFG_W-1:0] model_width = ROW_WIDTH_RESET;
    int unsigned          model_column = 0;
    logic [BITPOS_W-1:0]  model_bit = '0;
    logic [WORD_W-1:0]    model_one = '0;
    logic [WORD_W-1:0]    model_two = '0;

    t_planes     expected_words[$];
    int unsigned mismatch_count = 0;
    int unsigned burst_left = 0;

    t_dir_row directed_rows [DIR_ROWS] = '{
        // default width 16, then shrink mid-row so the next pixel closes it
        '{1'b0, 13'd0, '{8'hff, 8'hff, 8'hff, 8'hff}, 1'b0, '{16'h0000, 16'h0000, 1'b0}},
        '{1'b0, 13'd0, '{8'hff, 8'h00, 8'h00, 8'h00}, 1'b0, '{16'h0000, 16'h0000, 1'b0}},
        '{1'b0, 13'd0, '{8'h00, 8'hff, 8'hff, 8'hff}, 1'b0, '{16'h0000, 16'h0000, 1'b0}},
        '{1'b1, 13'd1, '{8'h00, 8'h00, 8'h00, 8'h00}, 1'b0, '{16'h0000, 16'h0000, 1'b0}},
        '{1'b0, 13'd0, '{8'h81, 8'h81, 8'h00, 8'h00}, 1'b1, '{16'h5000, 16'h9000, 1'b1}},
        // one pixel per row: alpha and level boundaries
        '{1'b0, 13'd0, '{8'h80, 8'hff, 8'hff, 8'hff}, 1'b1, '{16'h0000, 16'h0000, 1'b1}},
        '{1'b0, 13'd0, '{8'h81, 8'h00, 8'h00, 8'h00}, 1'b1, '{16'h8000, 16'h0000, 1'b1}},
        '{1'b0, 13'd0, '{8'hff, 8'h80, 8'h00, 8'h00}, 1'b1, '{16'h8000, 16'h0000, 1'b1}},
        '{1'b0, 13'd0, '{8'hff, 8'h81, 8'h00, 8'h00}, 1'b1, '{16'h8000, 16'h8000, 1'b1}},
        '{1'b0, 13'd0, '{8'hff, 8'hff, 8'hff, 8'h82}, 1'b1, '{16'h8000, 16'h8000, 1'b1}},
        '{1'b0, 13'd0, '{8'hff, 8'hff, 8'hff, 8'h83}, 1'b1, '{16'h0000, 16'h8000, 1'b1}},
        '{1'b0, 13'd0, '{8'hff, 8'hff, 8'hff, 8'hff}, 1'b1, '{16'h0000, 16'h8000, 1'b1}},
        '{1'b0, 13'd0, '{8'h00, 8'h00, 8'h00, 8'h00}, 1'b1, '{16'h0000, 16'h0000, 1'b1}},
        // zero width acts as one
        '{1'b1, 13'd0, '{8'h00, 8'h00, 8'h00, 8'h00}, 1'b0, '{16'h0000, 16'h0000, 1'b0}},
        '{1'b0, 13'd0, '{8'hff, 8'h00, 8'h00, 8'h00}, 1'b1, '{16'h8000, 16'h0000, 1'b1}},
        '{1'b1, 13'd3, '{8'h00, 8'h00, 8'h00, 8'h00}, 1'b0, '{16'h0000, 16'h0000, 1'b0}},
        '{1'b0, 13'd0, '{8'hff, 8'hff, 8'hff, 8'hff}, 1'b0, '{16'h0000, 16'h0000, 1'b0}},
        '{1'b0, 13'd0, '{8'h55, 8'haa, 8'h55, 8'haa}, 1'b0, '{16'h0000, 16'h0000, 1'b0}},
        '{1'b0, 13'd0, '{8'haa, 8'h55, 8'haa, 8'h55}, 1'b0, '{16'h0000, 16'h0000, 1'b0}},
        '{1'b1, 13'h1fff, '{8'h00, 8'h00, 8'h00, 8'h00}, 1'b0, '{16'h0000, 16'h0000, 1'b0}},
        '{1'b0, 13'd0, '{8'hff, 8'h12, 8'h34, 8'h56}, 1'b0, '{16'h0000, 16'h0000, 1'b0}}
    };

    argb_to_two_bitplanes uut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .o_in_stall       (in_stall),
        .i_alpha          (alpha),
        .i_red            (red),
        .i_green          (green),
        .i_blue           (blue),
        .o_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .o_plane_one_word (plane_one_word),
        .o_plane_two_word (plane_two_word),
        .o_row_done       (row_done),
        .i_cfg_valid      (cfg_valid),
        .o_cfg_ready      (cfg_ready),
        .i_cfg_row_width  (cfg_row_width)
    );

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial begin
        #2ms;
        $display("Simulation FAILED");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    function automatic int unsigned row_limit();
        int unsigned w;
        w = model_width;
        if (w == 0)
            w = 1;
        if (w > MAX_ROW)
            w = MAX_ROW;
        return w;
    endfunction

    // packs one pixel into the shadow words, returns 1 when a word leaves
    function automatic bit pack_pixel(input t_argb px, output t_planes w);
        logic [9:0]        level_sum;
        t_level            level;
        logic [WORD_W-1:0] mask;
        bit                row_end;
        mask = TOP_BIT >> model_bit;
        w = '0;
        if (px.alpha > ALPHA_LIMIT) begin
            level_sum = 10'(px.red) + 10'(px.green) + 10'(px.blue) + LEVEL_BIAS;
            level = t_level'(level_sum[9:8]);
            case (level)
                LVL_WHITE: begin
                    model_two |= mask;
                end
                LVL_LOW, LVL_HIGH: begin
                    model_one |= mask;
                    model_two |= mask;
                end
                default: begin
                    model_one |= mask;
                end
            endcase
        end
        model_column++;
        model_bit = model_bit + 1'b1;
        row_end = (model_column >= row_limit());
        if (model_bit != 0 && !row_end)
            return 1'b0;
        w.one = model_one;
        w.two = model_two;
        w.done = row_end;
        model_one = '0;
        model_two = '0;
        model_bit = '0;
        if (row_end)
            model_column = 0;
        return 1'b1;
    endfunction

    function automatic t_argb random_pixel();
        t_argb px;
        int    target;
        int    rest;
        px.alpha = 8'($urandom_range(0, 255));
        px.red = 8'($urandom_range(0, 255));
        px.green = 8'($urandom_range(0, 255));
        px.blue = 8'($urandom_range(0, 255));
        case ($urandom_range(0, 7))
            0: px.alpha = 8'h80;
            1: px.alpha = 8'h81;
            2, 3: begin
                // land on a level boundary
                case ($urandom_range(0, 5))
                    0: target = 128;
                    1: target = 129;
                    2: target = 384;
                    3: target = 385;
                    4: target = 640;
                    default: target = 641;
                endcase
                px.red = 8'($urandom_range(0, target / 3));
                px.green = 8'($urandom_range(0, target / 3));
                rest = target - px.red - px.green;
                if (rest <= 255)
                    px.blue = 8'(rest);
            end
            default: ;
        endcase
        return px;
    endfunction

    task automatic send_pixel(input t_argb px, input bit known, input t_planes typed);
        int      gap;
        t_planes w;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 10);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        in_valid <= 1'b1;
        alpha <= px.alpha;
        red <= px.red;
        green <= px.green;
        blue <= px.blue;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        burst_left--;
        if (pack_pixel(px, w))
            expected_words.push_back(known ? typed : w);
    endtask

    task automatic wait_idle();
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_width(input logic [ROW_CFG_W-1:0] w);
        cfg_valid <= 1'b1;
        cfg_row_width <= w;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        model_width = w;
    endtask

    // receiver stall pattern with two long hold-offs
    initial begin
        int unsigned cycles;
        int unsigned seg;
        int unsigned mode;
        int unsigned holds;
        cycles = 0;
        holds = 0;
        forever begin
            if (holds < 2 && cycles > 400 + holds * 2500) begin
                @(posedge clk);
                out_stall <= 1'b1;
                repeat (299) @(posedge clk);
                cycles += 300;
                holds++;
            end
            seg = $urandom_range(20, 200);
            mode = $urandom_range(0, 3);
            repeat (seg) begin
                @(posedge clk);
                case (mode)
                    0: out_stall <= 1'b0;
                    1: out_stall <= ($urandom_range(0, 3) == 0);
                    2: out_stall <= ($urandom_range(0, 1) == 0);
                    default: out_stall <= ($urandom_range(0, 7) != 0);
                endcase
                cycles++;
            end
        end
    end

    always @(posedge clk) begin
        t_planes want;
        if (rst_n && out_valid && !out_stall) begin
            if (expected_words.size() == 0) begin
                report_mismatch($sformatf("unexpected word %h %h done %b",
                    plane_one_word, plane_two_word, row_done));
            end else begin
                want = expected_words.pop_front();
                if (plane_one_word !== want.one)
                    report_mismatch($sformatf("plane_one_word expected %h got %h",
                        want.one, plane_one_word));
                if (plane_two_word !== want.two)
                    report_mismatch($sformatf("plane_two_word expected %h got %h",
                        want.two, plane_two_word));
                if (row_done !== want.done)
                    report_mismatch($sformatf("row_done expected %b got %b",
                        want.done, row_done));
            end
        end
    end

    initial begin
        t_dir_row             row;
        int unsigned          sent;
        int unsigned          phase_len;
        int unsigned          drain;
        logic [ROW_CFG_W-1:0] w;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < DIR_ROWS; i++) begin
            row = directed_rows[i];
            if (row.is_cfg) begin
                in_valid <= 1'b0;
                wait_idle();
                write_width(row.width);
            end else begin
                send_pixel(row.px, row.known, row.words);
            end
        end

        sent = 0;
        while (sent < RANDOM_PIXELS) begin
            in_valid <= 1'b0;
            wait_idle();
            case ($urandom_range(0, 9))
                0: w = 13'd0;
                1: w = 13'd1;
                2: w = 13'd16;
                3: w = 13'd32;
                4: w = 13'($urandom_range(MAX_ROW + 1, 8191));
                5: w = 13'(MAX_ROW);
                default: w = 13'($urandom_range(2, 48));
            endcase
            write_width(w);
            phase_len = $urandom_range(10, 120);
            repeat (phase_len) send_pixel(random_pixel(), 1'b0, '0);
            sent += phase_len;
        end

        in_valid <= 1'b0;
        drain = 0;
        while (expected_words.size() != 0 && drain < 20000) begin
            @(posedge clk);
            drain++;
        end
        repeat (8) @(posedge clk);
        if (expected_words.size() != 0)
            report_mismatch($sformatf("%0d words never arrived", expected_words.size()));
        if (mismatch_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
